/* src/owtr_pkg.sv */
// owtr_pkg: shared types, command bytes and the tenths conversion for the
// one-wire temperature reader. No dependencies.
`default_nettype none

package owtr_pkg;

  // Sequence phases
  typedef enum logic [4:0] {
    ST_RST_LOW = 5'd0,
    ST_RST_REC = 5'd1,
    ST_WR_A    = 5'd2,
    ST_WR_B    = 5'd3,
    ST_RD_LOW  = 5'd4,
    ST_RD_REL  = 5'd5,
    ST_RD_WAIT = 5'd6,
    ST_REPORT  = 5'd7,
    ST_GAP     = 5'd8
  } step_t;

  // Configuration register indexes
  localparam logic [7:0] CFG_RESET_LOW = 8'd0;
  localparam logic [7:0] CFG_RECOVERY  = 8'd1;
  localparam logic [7:0] CFG_SHORT     = 8'd2;
  localparam logic [7:0] CFG_SLOT      = 8'd3;
  localparam logic [7:0] CFG_GAP       = 8'd4;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_SP  = 8'hBE;

  // Commands bits 0..31 are taken from these bytes in order
  localparam logic [5:0] WRITE_BITS = 6'd32;
  localparam logic [5:0] FIRST_HALF = 6'd16;
  localparam logic [4:0] READ_BITS  = 5'd16;

  typedef struct packed {
    logic               drive_low;
    logic               reading_valid;
    logic signed [15:0] raw_reading;
    logic signed [15:0] temperature_tenths;
  } result_t;

  typedef struct packed {
    step_t step;
  } status_t;

  function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CMD_SKIP_ROM;
      2'd1:    b = CMD_CONVERT;
      2'd2:    b = CMD_SKIP_ROM;
      default: b = CMD_READ_SP;
    endcase
    return b;
  endfunction

  // floor((raw*10+8)/16): arithmetic shift of a 20-bit sum
  function automatic logic signed [15:0] to_tenths(input logic [15:0] raw);
    logic [19:0] ext;
    logic [19:0] v;
    ext = {{4{raw[15]}}, raw};
    v   = (ext << 3) + (ext << 1) + 20'd8;
    return v[19:4];
  endfunction

endpackage

`default_nettype wire

/* src/owtr_seq.sv */
// owtr_seq: bus sequencer, configuration registers and phase timer.
// Depends on owtr_pkg.
`default_nettype none

module owtr_seq (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   advance,   // tick accepted this cycle
  input  wire                   bus_in,
  input  wire                   cfg_we,
  input  wire  [7:0]            cfg_index,
  input  wire  [23:0]           cfg_data,
  output owtr_pkg::result_t     result,
  output owtr_pkg::status_t     status
);

  logic [15:0] reset_low_ticks;
  logic [15:0] recovery_ticks;
  logic [7:0]  short_ticks;
  logic [7:0]  slot_ticks;
  logic [23:0] cycle_gap_ticks;

  owtr_pkg::step_t step, step_next;
  logic [23:0] tick_count, tick_count_next;
  logic [4:0]  bit_count, bit_count_next;
  logic [7:0]  command_shift, command_shift_next;
  logic [15:0] read_shift, read_shift_next;
  logic [15:0] last_temperature, last_temperature_next;

  logic [23:0] phase_len, len;
  logic [23:0] tick_inc;
  logic        done;
  logic        bit_val;
  logic [5:0]  wr_n;
  logic [4:0]  rd_n;
  logic [15:0] tenths_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_ticks <= 16'd480;
      recovery_ticks  <= 16'd480;
      short_ticks     <= 8'd2;
      slot_ticks      <= 8'd60;
      cycle_gap_ticks <= 24'd100000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        owtr_pkg::CFG_RESET_LOW: reset_low_ticks <= cfg_data[15:0];
        owtr_pkg::CFG_RECOVERY:  recovery_ticks  <= cfg_data[15:0];
        owtr_pkg::CFG_SHORT:     short_ticks     <= cfg_data[7:0];
        owtr_pkg::CFG_SLOT:      slot_ticks      <= cfg_data[7:0];
        owtr_pkg::CFG_GAP:       cycle_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign bit_val    = command_shift[0];
  assign tick_inc   = tick_count + 24'd1;
  assign wr_n       = {1'b0, bit_count} + 6'd1;
  assign rd_n       = bit_count + 5'd1;
  assign tenths_new = owtr_pkg::to_tenths(read_shift);

  // phase length for the current step; zero acts as one tick
  always_comb begin
    case (step)
      owtr_pkg::ST_RST_LOW: phase_len = {8'd0, reset_low_ticks};
      owtr_pkg::ST_RST_REC: phase_len = {8'd0, recovery_ticks};
      owtr_pkg::ST_WR_A:    phase_len = {16'd0, bit_val ? short_ticks : slot_ticks};
      owtr_pkg::ST_WR_B:    phase_len = {16'd0, bit_val ? slot_ticks : short_ticks};
      owtr_pkg::ST_RD_LOW,
      owtr_pkg::ST_RD_REL:  phase_len = {16'd0, short_ticks};
      owtr_pkg::ST_RD_WAIT: phase_len = {16'd0, slot_ticks};
      owtr_pkg::ST_GAP:     phase_len = cycle_gap_ticks;
      default:              phase_len = 24'd1;
    endcase
    len  = (phase_len == 24'd0) ? 24'd1 : phase_len;
    done = (tick_inc >= len);
  end

  // next state
  always_comb begin
    step_next             = step;
    tick_count_next       = done ? 24'd0 : tick_inc;
    bit_count_next        = bit_count;
    command_shift_next    = command_shift;
    read_shift_next       = read_shift;
    last_temperature_next = last_temperature;
    unique case (step)
      owtr_pkg::ST_RST_LOW: if (done) step_next = owtr_pkg::ST_RST_REC;
      owtr_pkg::ST_RST_REC: if (done) begin
        command_shift_next = owtr_pkg::cmd_byte(bit_count[4:3]);
        step_next          = owtr_pkg::ST_WR_A;
      end
      owtr_pkg::ST_WR_A: if (done) step_next = owtr_pkg::ST_WR_B;
      owtr_pkg::ST_WR_B: if (done) begin
        command_shift_next = {1'b0, command_shift[7:1]};
        if (wr_n >= owtr_pkg::WRITE_BITS) begin
          bit_count_next  = 5'd0;
          read_shift_next = 16'd0;
          step_next       = owtr_pkg::ST_RD_LOW;
        end else begin
          bit_count_next = wr_n[4:0];
          if (wr_n == owtr_pkg::FIRST_HALF) begin
            step_next = owtr_pkg::ST_RST_LOW;
          end else begin
            if (wr_n[2:0] == 3'd0) command_shift_next = owtr_pkg::cmd_byte(wr_n[4:3]);
            step_next = owtr_pkg::ST_WR_A;
          end
        end
      end
      owtr_pkg::ST_RD_LOW: if (done) step_next = owtr_pkg::ST_RD_REL;
      owtr_pkg::ST_RD_REL: if (done) begin
        read_shift_next = {bus_in, read_shift[15:1]};
        step_next       = owtr_pkg::ST_RD_WAIT;
      end
      owtr_pkg::ST_RD_WAIT: if (done) begin
        if (rd_n >= owtr_pkg::READ_BITS) begin
          bit_count_next = 5'd0;
          step_next      = owtr_pkg::ST_REPORT;
        end else begin
          bit_count_next = rd_n;
          step_next      = owtr_pkg::ST_RD_LOW;
        end
      end
      owtr_pkg::ST_REPORT: begin
        last_temperature_next = tenths_new;
        tick_count_next       = 24'd0;
        step_next = (cycle_gap_ticks == 24'd0) ? owtr_pkg::ST_RST_LOW : owtr_pkg::ST_GAP;
      end
      owtr_pkg::ST_GAP: if (done) step_next = owtr_pkg::ST_RST_LOW;
      default: begin
        tick_count_next = 24'd0;
        bit_count_next  = 5'd0;
        step_next       = owtr_pkg::ST_RST_LOW;
      end
    endcase
  end

  // outputs for this tick, from the state before the update
  always_comb begin
    result.drive_low          = 1'b0;
    result.reading_valid      = 1'b0;
    result.raw_reading        = 16'sd0;
    result.temperature_tenths = last_temperature;
    unique case (step)
      owtr_pkg::ST_RST_LOW,
      owtr_pkg::ST_WR_A,
      owtr_pkg::ST_RD_LOW: result.drive_low = 1'b1;
      owtr_pkg::ST_REPORT: begin
        result.reading_valid      = 1'b1;
        result.raw_reading        = read_shift;
        result.temperature_tenths = tenths_new;
      end
      default: ;
    endcase
  end

  assign status.step = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step             <= owtr_pkg::ST_RST_LOW;
      tick_count       <= 24'd0;
      bit_count        <= 5'd0;
      command_shift    <= 8'd0;
      read_shift       <= 16'd0;
      last_temperature <= 16'd0;
    end else if (advance) begin
      step             <= step_next;
      tick_count       <= tick_count_next;
      bit_count        <= bit_count_next;
      command_shift    <= command_shift_next;
      read_shift       <= read_shift_next;
      last_temperature <= last_temperature_next;
    end
  end

endmodule

`default_nettype wire

/* src/owtr_out_reg.sv */
// owtr_out_reg: result register between the sequencer and the master stream.
// Depends on owtr_pkg.
`default_nettype none

module owtr_out_reg (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  owtr_pkg::result_t  in_result,
  output logic               out_valid,
  input  wire                out_ready,
  output owtr_pkg::result_t  out_result
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_result <= in_result;
    end
  end

endmodule

`default_nettype wire

/* src/one_wire_temperature_reader.sv */
// one_wire_temperature_reader: top level, one-wire bus master that keeps
// reading a temperature sensor. Depends on owtr_pkg, owtr_seq, owtr_out_reg.
//
// Usage:
//  - Slave stream: one item per timebase tick; s_tdata[0] is the sampled bus
//    level (1 = released). The bus timing advances only on accepted items.
//  - Master stream: one item per accepted tick. m_tdata carries the pull-low
//    drive for that tick, the raw scratchpad word and the tenths value;
//    m_tuser marks the single tick on which a new reading is reported.
//  - Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always
//    ready. Indexes 0..4: reset low, recovery, short, slot, cycle gap ticks.
//    Unknown indexes are dropped. Write only while the stream is quiet.
//  - Output: each accepted tick's result is registered and appears as an item in the cycle after the tick.
//  - Throughput: one tick per cycle while s_tready is high; the sequencer is a single registered
//    step whose next state is settled in the same cycle.
//  - Stall: one output register; s_tready drops only while the result
//    register is full and m_tready is low, and the timing freezes with it.
//  - Reset: rst (synchronous) restores default timings, starts at the first
//    reset pulse and empties the result register.
`default_nettype none

module one_wire_temperature_reader (
  input  wire         clk,
  input  wire         rst,
  // slave stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [0] bus_in, [7:1] zero
  // master stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // [0] bus_drive_low, [16:1] raw_reading,
                                 // [32:17] temperature_tenths, [39:33] zero
  output logic        m_tuser,   // [0] reading_valid
  // configuration write
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_index,
  input  wire  [23:0] cfg_data
);

  owtr_pkg::result_t seq_result;
  owtr_pkg::result_t out_result;
  owtr_pkg::status_t seq_status;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  owtr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .bus_in    (s_tdata[0]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (seq_result),
    .status    (seq_status)
  );

  owtr_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_result  (seq_result),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  assign m_tdata = {7'd0, out_result.temperature_tenths, out_result.raw_reading,
                    out_result.drive_low};
  assign m_tuser = out_result.reading_valid;

  // a report tick never drives the bus
  a_report_released: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[0])
    else $error("bus driven on report tick");

  // raw word is only shown on the report tick
  a_raw_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[16:1] == 16'd0)
    else $error("raw reading outside report tick");

  // after a report the sequencer goes to the gap or a new reset pulse
  a_report_next: assert property (@(posedge clk) disable iff (rst)
    accept && seq_status.step == owtr_pkg::ST_REPORT |=>
      seq_status.step == owtr_pkg::ST_GAP || seq_status.step == owtr_pkg::ST_RST_LOW)
    else $error("bad step after report");

endmodule

`default_nettype wire
